>>> design/cla_pkg.sv
// Package for the console line assembler.
// Holds the beat descriptor type, byte codes and the acknowledgement text.
// No dependencies.
`default_nettype none

package cla_pkg;

  // Received byte codes with special meaning
  localparam logic [7:0] KEY_BS = 8'h08;
  localparam logic [7:0] KEY_LF = 8'h0A;
  localparam logic [7:0] KEY_CR = 8'h0D;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Kinds of burst handed from the editor to the emitter
  localparam logic [1:0] KIND_ECHO = 2'd0;  // one byte, echo or backspace
  localparam logic [1:0] KIND_CRLF = 2'd1;  // CR LF after a line overflow
  localparam logic [1:0] KIND_ACK  = 2'd2;  // "[OK]\r\n" for a finished line

  localparam int unsigned ACK_BEATS = 6;
  localparam logic [2:0] ACK_FINAL = 3'(ACK_BEATS - 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;    // byte to echo for KIND_ECHO
    logic [7:0] length;  // completed line length for KIND_ACK
  } burst_t;

  // Characters of the acknowledgement text by beat
  function automatic logic [7:0] ack_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h5B;  // '['
      3'd1: c = 8'h4F;  // 'O'
      3'd2: c = 8'h4B;  // 'K'
      3'd3: c = 8'h5D;  // ']'
      3'd4: c = KEY_CR;
      3'd5: c = KEY_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/cla_editor.sv
// Line editor: holds the line length and the CR flag, classifies each
// accepted byte and describes the burst of output beats it causes.
// Depends on cla_pkg.
`default_nettype none

module cla_editor
  import cla_pkg::*;
#(
  parameter int LINE_SIZE = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            has_burst,
  output burst_t          burst
);

  localparam int LW = $clog2(LINE_SIZE);
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_SIZE - 1);

  logic [LW-1:0] line_length;
  logic [LW-1:0] line_length_next;
  logic          cr_seen;
  logic          cr_seen_next;
  logic          printable;
  logic [LW+7:0] len_wide;

  assign printable = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);
  assign len_wide  = {8'b0, line_length};

  // Classify the byte and work out the new state and burst
  always_comb begin
    line_length_next = line_length;
    cr_seen_next     = cr_seen;
    has_burst        = 1'b0;
    burst.kind       = KIND_ECHO;
    burst.data       = rx_byte;
    burst.length     = len_wide[7:0];
    if (rx_byte == KEY_BS) begin
      if (line_length != '0) begin
        line_length_next = line_length - 1'b1;
        has_burst        = 1'b1;
      end
    end else if (rx_byte != KEY_CR && rx_byte != KEY_LF && !printable) begin
      // drop other control bytes and high bytes
    end else if (cr_seen && rx_byte != KEY_LF) begin
      line_length_next = '0;
      cr_seen_next     = 1'b0;
    end else if (!cr_seen && rx_byte == KEY_CR) begin
      cr_seen_next = 1'b1;
    end else if (!cr_seen && rx_byte != KEY_LF) begin
      has_burst = 1'b1;
      if (line_length == LEN_MAX) begin
        line_length_next = '0;
        cr_seen_next     = 1'b0;
        burst.kind       = KIND_CRLF;
      end else begin
        line_length_next = line_length + 1'b1;
      end
    end else begin
      // line complete
      has_burst        = 1'b1;
      burst.kind       = KIND_ACK;
      line_length_next = '0;
      cr_seen_next     = 1'b0;
    end
  end

  // Advance the line state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      cr_seen     <= 1'b0;
    end else if (accept) begin
      line_length <= line_length_next;
      cr_seen     <= cr_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> design/cla_emitter.sv
// Burst emitter: a pending slot and an active slot, the active one
// stepped beat by beat onto the output channel.
// Depends on cla_pkg.
`default_nettype none

module cla_emitter
  import cla_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire burst_t     push_burst,
  output logic            slot_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      tx_byte,
  output logic            last,
  output logic            line_done,
  output logic [7:0]      done_length
);

  logic   pend_valid;
  burst_t pend;
  logic   act_valid;
  burst_t act;
  logic [2:0] beat;
  logic   beat_done;
  logic   pop;
  logic   move;

  assign beat_done = out_valid && out_ready;
  assign pop       = beat_done && last;
  assign move      = !act_valid || pop;
  assign slot_free = !pend_valid || move;

  // Drive the output beat from the active burst
  always_comb begin
    out_valid   = act_valid;
    line_done   = 1'b0;
    done_length = 8'h00;
    case (act.kind)
      KIND_ECHO: begin
        tx_byte = act.data;
        last    = 1'b1;
      end
      KIND_CRLF: begin
        tx_byte = (beat == 3'd0) ? KEY_CR : KEY_LF;
        last    = (beat != 3'd0);
      end
      KIND_ACK: begin
        tx_byte     = ack_char(beat);
        last        = (beat == ACK_FINAL);
        line_done   = 1'b1;
        done_length = act.length;
      end
      default: begin
        tx_byte = act.data;
        last    = 1'b1;
      end
    endcase
  end

  // Hold and hand over bursts, count beats
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      act_valid  <= 1'b0;
      beat       <= 3'd0;
    end else begin
      if (move) begin
        act_valid  <= pend_valid;
        beat       <= 3'd0;
        pend_valid <= push;
      end else begin
        if (beat_done) begin
          beat <= beat + 3'd1;
        end
        if (push) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (move) begin
      act <= pend;
    end
    if (push) begin
      pend <= push_burst;
    end
  end

endmodule

`default_nettype wire

>>> design/console_line_assembler.sv
// Console line assembler: line editing and echo for a serial console.
// Input channel in_valid/in_ready carries one received byte per beat
// (rx_byte). Output channel out_valid/out_ready carries the bytes to send
// back: tx_byte, with last on the final byte caused by an input byte, and
// line_done/done_length on each byte of the "[OK]\r\n" acknowledgement.
// An input byte causes none, one, two (CR LF on overflow) or six beats.
// An accepted byte's burst is registered in the pending slot and then moved
// into the active slot, and only there does its first output beat show.
// Output runs at one beat per cycle while out_ready stays high and bursts
// are waiting. A pending slot in front of the active burst lets the next
// byte be taken while earlier beats still wait.
// While the receiver stalls, the current beat holds unchanged, the pending
// slot fills and in_ready then drops until the active burst finishes.
// Reset (rst, synchronous) empties the line, clears the CR flag and drops
// any beats not yet sent.
// Depends on cla_pkg, cla_editor and cla_emitter.
`default_nettype none

module console_line_assembler
  import cla_pkg::*;
#(
  parameter int LINE_SIZE = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      tx_byte,
  output logic            last,
  output logic            line_done,
  output logic [7:0]      done_length
);

  logic   accept;
  logic   has_burst;
  burst_t burst;

  assign accept = in_valid && in_ready;

  // Edit the line and describe the output burst
  cla_editor #(
    .LINE_SIZE (LINE_SIZE)
  ) u_editor (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .has_burst (has_burst),
    .burst     (burst)
  );

  // Send the bursts beat by beat
  cla_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && has_burst),
    .push_burst  (burst),
    .slot_free   (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_byte     (tx_byte),
    .last        (last),
    .line_done   (line_done),
    .done_length (done_length)
  );

endmodule

`default_nettype wire
